FILE: sv/utp_pkg.sv
package utp_pkg;

	localparam logic [20:0] REPL_CP = 21'h00FFFD;

	localparam logic [1:0] CLS_WORD  = 2'd0;
	localparam logic [1:0] CLS_ALONE = 2'd1;
	localparam logic [1:0] CLS_END   = 2'd2;

	// results of one byte: replacement run, then one character, then end marker
	typedef struct packed {
		logic [2:0]  nrepl;
		logic        repl_begins;
		logic        has_x;
		logic [20:0] x_cp;
		logic [1:0]  x_class;
		logic        x_begins;
		logic        has_end;
	} desc_t;

	function automatic logic rng(input logic [20:0] c, input logic [20:0] lo,
		input logic [20:0] hi);
		return (c >= lo) && (c <= hi);
	endfunction

	function automatic logic is_space(input logic [20:0] c);
		return c == 21'h20 || c == 21'h09 || c == 21'h0A || c == 21'h0D ||
			c == 21'hA0 || c == 21'h1680 || rng(c, 21'h2000, 21'h200A) ||
			c == 21'h202F || c == 21'h205F || c == 21'h3000;
	endfunction

	function automatic logic is_control(input logic [20:0] c);
		logic tab_nl;
		tab_nl = c == 21'h09 || c == 21'h0A || c == 21'h0D;
		return !tab_nl && (c < 21'h20 || rng(c, 21'h7F, 21'h9F));
	endfunction

	function automatic logic is_punct(input logic [20:0] c);
		return rng(c, 21'h21, 21'h2F) || rng(c, 21'h3A, 21'h40) ||
			rng(c, 21'h5B, 21'h60) || rng(c, 21'h7B, 21'h7E) ||
			rng(c, 21'hA1, 21'hBF) || rng(c, 21'h2000, 21'h206F) ||
			rng(c, 21'h3000, 21'h303F) || rng(c, 21'hFF01, 21'hFF0F) ||
			rng(c, 21'hFF1A, 21'hFF20) || rng(c, 21'hFF3B, 21'hFF40) ||
			rng(c, 21'hFF5B, 21'hFF65);
	endfunction

	function automatic logic is_cjk(input logic [20:0] c);
		return rng(c, 21'h4E00, 21'h9FFF) || rng(c, 21'h3400, 21'h4DBF) ||
			rng(c, 21'hF900, 21'hFAFF) || rng(c, 21'h20000, 21'h2A6DF) ||
			rng(c, 21'h2A700, 21'h2B73F) || rng(c, 21'h2B740, 21'h2B81F) ||
			rng(c, 21'h2B820, 21'h2CEAF) || rng(c, 21'h2CEB0, 21'h2EBEF) ||
			rng(c, 21'h30000, 21'h3134F);
	endfunction

endpackage

FILE: sv/utp_byte_if.sv
interface utp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_input;

	modport source(output valid, output text_byte, output end_of_input, input ready);
	modport sink(input valid, input text_byte, input end_of_input, output ready);
endinterface

FILE: sv/utp_char_if.sv
interface utp_char_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic [1:0]  char_class;
	logic        begins_word;
	logic        text_end;
	logic        run_last;

	modport source(output valid, output code_point, output char_class,
		output begins_word, output text_end, output run_last, input ready);
	modport sink(input valid, input code_point, input char_class,
		input begins_word, input text_end, input run_last, output ready);
endinterface

FILE: sv/utf8_pretokenizer_core.sv
// channel  dir  handshake      payload
// text     in   valid/ready    text_byte[7:0], end_of_input
// chars    out  valid/ready    code_point[20:0], char_class[1:0], begins_word,
//                              text_end, run_last
//
// a byte is decoded and classified in the cycle it is taken; its words leave
// through a run register and an output register, one word per cycle unless chars stalls
// a byte yielding one word or none sustains one byte per cycle while chars does not
// stall; a byte yielding n words holds text until its last word advances, up to five
// arst_n clears the utf-8 decoder, the open word and the valid state of both registers
// a stall on chars backs up through the output and run registers to text.ready
module utf8_pretokenizer_core (
	input  logic       clk,
	input  logic       arst_n,
	utp_byte_if.sink   text,
	utp_char_if.source chars
);
	import utp_pkg::*;

	desc_t desc;
	logic  take, rdy, x_drop;

	assign take       = text.valid && rdy;
	assign text.ready = rdy;
	assign x_drop     = is_control(desc.x_cp) || is_space(desc.x_cp);

	utp_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.text_byte    (text.text_byte),
		.end_of_input (text.end_of_input),
		.desc         (desc)
	);

	utp_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.desc     (desc),
		.x_drop   (x_drop),
		.in_ready (rdy),
		.chars    (chars)
	);
endmodule

FILE: sv/utp_decode.sv
module utp_decode (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  logic [7:0]     text_byte,
	input  logic           end_of_input,
	output utp_pkg::desc_t desc
);
	import utp_pkg::*;

	logic [1:0]  exp_q, held_q;
	logic [20:0] pc_q;
	logic        wo_q;

	logic [1:0]  exp_d, held_d, held_inc, exp_dec;
	logic [20:0] pc_d, pc_ext;
	logic        wo_d, wo_r, cont;
	logic        x_ctrl, x_space, x_alone;

	logic [2:0]  nrepl;
	logic        has_x;
	logic [20:0] cp_x;
	logic [1:0]  cls_x;
	logic        bw_x;

	assign cont     = text_byte[7:6] == 2'b10;
	assign pc_ext   = {pc_q[14:0], text_byte[5:0]};
	assign held_inc = held_q + 2'd1;
	assign exp_dec  = exp_q - 2'd1;

	// sequence decode
	always_comb begin
		exp_d  = exp_q;
		held_d = held_q;
		pc_d   = pc_q;
		nrepl  = 3'd0;
		has_x  = 1'b0;
		cp_x   = 21'd0;
		if (exp_q != 2'd0 && cont) begin
			if (exp_dec == 2'd0) begin
				has_x  = 1'b1;
				cp_x   = pc_ext;
				exp_d  = 2'd0;
				held_d = 2'd0;
				pc_d   = 21'd0;
			end else if (end_of_input) begin
				nrepl = {1'b0, held_inc} + 3'd1;
			end else begin
				exp_d  = exp_dec;
				held_d = held_inc;
				pc_d   = pc_ext;
			end
		end else begin
			if (exp_q != 2'd0) begin
				nrepl = {1'b0, held_q} + 3'd1;
			end
			exp_d  = 2'd0;
			held_d = 2'd0;
			pc_d   = 21'd0;
			if (!text_byte[7]) begin
				has_x = 1'b1;
				cp_x  = {14'd0, text_byte[6:0]};
			end else if (!text_byte[6] || end_of_input) begin
				nrepl = nrepl + 3'd1;
			end else begin
				priority if (text_byte[5:4] == 2'b11) begin
					exp_d = 2'd3;
					pc_d  = {18'd0, text_byte[2:0]};
				end else if (text_byte[5]) begin
					exp_d = 2'd2;
					pc_d  = {17'd0, text_byte[3:0]};
				end else begin
					exp_d = 2'd1;
					pc_d  = {16'd0, text_byte[4:0]};
				end
			end
		end
		if (end_of_input) begin
			exp_d  = 2'd0;
			held_d = 2'd0;
			pc_d   = 21'd0;
		end
	end

	// character class and word tracking
	assign x_ctrl  = is_control(cp_x);
	assign x_space = is_space(cp_x);
	assign x_alone = is_punct(cp_x) || is_cjk(cp_x);
	assign wo_r    = (nrepl != 3'd0) ? 1'b1 : wo_q;

	always_comb begin
		cls_x = CLS_WORD;
		bw_x  = !wo_r;
		wo_d  = wo_r;
		if (has_x && !x_ctrl) begin
			if (x_space) begin
				wo_d = 1'b0;
			end else if (x_alone) begin
				cls_x = CLS_ALONE;
				bw_x  = 1'b1;
				wo_d  = 1'b0;
			end else begin
				wo_d = 1'b1;
			end
		end
		if (end_of_input) begin
			wo_d = 1'b0;
		end
	end

	assign desc = '{nrepl: nrepl, repl_begins: !wo_q, has_x: has_x, x_cp: cp_x,
		x_class: cls_x, x_begins: bw_x, has_end: end_of_input};

	// the emitter drops characters that are control or whitespace
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q  <= 2'd0;
			held_q <= 2'd0;
			pc_q   <= 21'd0;
			wo_q   <= 1'b0;
		end else if (take) begin
			exp_q  <= exp_d;
			held_q <= held_d;
			pc_q   <= pc_d;
			wo_q   <= wo_d;
		end
	end

	logic x_keep;
	assign x_keep = has_x && !x_ctrl && !x_space;

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && end_of_input |=> exp_q == 2'd0 && held_q == 2'd0 && !wo_q)
		else $error("decoder not cleared after end of text");
	a_seq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, exp_q} + {1'b0, held_q}) <= 3'd3)
		else $error("sequence length exceeds four bytes");
	a_keep_word: assert property (@(posedge clk) disable iff (!arst_n)
		take && x_keep && cls_x == CLS_WORD |=> wo_q || $past(end_of_input))
		else $error("word character left no open word");
endmodule

FILE: sv/utp_emit.sv
module utp_emit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  utp_pkg::desc_t desc,
	input  logic           x_drop,
	output logic           in_ready,
	utp_char_if.source     chars
);
	import utp_pkg::*;

	logic [2:0]  rep_q;
	logic        rb_q, xp_q, ep_q;
	logic [20:0] xcp_q;
	logic [1:0]  xcls_q;
	logic        xbw_q;

	logic        out_v_q;
	logic [20:0] cp_s2;
	logic [1:0]  cls_s2;
	logic        bw_s2, te_s2, last_s2;

	logic        busy, advance, load, has_x;
	logic [20:0] it_cp;
	logic [1:0]  it_cls;
	logic        it_bw, it_te, it_last;

	assign has_x    = desc.has_x && !x_drop;
	assign busy     = (rep_q != 3'd0) || xp_q || ep_q;
	assign advance  = busy && (!out_v_q || chars.ready);
	assign in_ready = !busy || (advance && it_last);
	assign load     = take && (desc.nrepl != 3'd0 || has_x || desc.has_end);

	// pick the next word of the run
	always_comb begin
		if (rep_q != 3'd0) begin
			it_cp   = REPL_CP;
			it_cls  = CLS_WORD;
			it_bw   = rb_q;
			it_te   = 1'b0;
			it_last = rep_q == 3'd1 && !xp_q && !ep_q;
		end else if (xp_q) begin
			it_cp   = xcp_q;
			it_cls  = xcls_q;
			it_bw   = xbw_q;
			it_te   = 1'b0;
			it_last = !ep_q;
		end else begin
			it_cp   = 21'd0;
			it_cls  = CLS_END;
			it_bw   = 1'b0;
			it_te   = 1'b1;
			it_last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_q <= 3'd0;
			rb_q  <= 1'b0;
			xp_q  <= 1'b0;
			ep_q  <= 1'b0;
		end else if (load) begin
			rep_q <= desc.nrepl;
			rb_q  <= desc.repl_begins;
			xp_q  <= has_x;
			ep_q  <= desc.has_end;
		end else if (advance) begin
			if (rep_q != 3'd0) begin
				rep_q <= rep_q - 3'd1;
				rb_q  <= 1'b0;
			end else if (xp_q) begin
				xp_q <= 1'b0;
			end else begin
				ep_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			xcp_q  <= desc.x_cp;
			xcls_q <= desc.x_class;
			xbw_q  <= desc.x_begins;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= 1'b1;
		end else if (chars.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cp_s2   <= it_cp;
			cls_s2  <= it_cls;
			bw_s2   <= it_bw;
			te_s2   <= it_te;
			last_s2 <= it_last;
		end
	end

	assign chars.valid       = out_v_q;
	assign chars.code_point  = cp_s2;
	assign chars.char_class  = cls_s2;
	assign chars.begins_word = bw_s2;
	assign chars.text_end    = te_s2;
	assign chars.run_last    = last_s2;

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && te_s2 |-> last_s2 && cp_s2 == 21'd0 && cls_s2 == CLS_END)
		else $error("end marker malformed");
	a_alone_begins: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && cls_s2 == CLS_ALONE |-> bw_s2)
		else $error("standalone character does not begin a word");
	a_take_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy)
		else $error("loaded run lost");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		take && busy |-> advance && it_last)
		else $error("byte taken while run pending");
endmodule
